// ===== rtl/core/rs2i_pkg.sv =====
// ----------------------------------------------------------------------------
// rs2i_pkg
// shared types and constants of the radix string to integer converter
// ----------------------------------------------------------------------------
`default_nettype none

package rs2i_pkg;

	// character codes that bound the digit ranges
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
	localparam logic [7:0] CHAR_LO_A  = 8'h61;
	localparam logic [7:0] CHAR_LO_Z  = 8'h7A;

	// digit values of letters start here; largest legal base
	localparam logic [5:0] LETTER_BASE = 6'd10;
	localparam logic [5:0] MAX_BASE    = 6'd36;

	// radix after reset and register address
	localparam logic [5:0] RADIX_RESET = 6'd10;
	localparam logic [1:0] ADDR_RADIX  = 2'd0;

	// status codes of a result
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_DIGIT = 2'd1,
		ST_BAD_BASE  = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	// input request
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_req_t;

	// result
	typedef struct packed {
		logic [30:0] value;
		logic [1:0]  status;
	} out_res_t;

	// classified character held in the queue
	typedef struct packed {
		logic [5:0] digit;
		status_t    status;
		logic       last;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/rs2i_front.sv =====
// ----------------------------------------------------------------------------
// rs2i_front
// classifies one character into a digit and a preliminary status
// ----------------------------------------------------------------------------
`default_nettype none

module rs2i_front (
	input  var rs2i_pkg::in_req_t in_req,
	input  wire logic [5:0]       radix,
	output rs2i_pkg::entry_t      entry
);

	logic [7:0] code;
	logic       is_num;
	logic       is_upper;
	logic       is_lower;
	logic [5:0] digit;

	assign code = in_req.char_code;

	// range checks
	assign is_num   = (code >= rs2i_pkg::CHAR_0)    && (code <= rs2i_pkg::CHAR_9);
	assign is_upper = (code >= rs2i_pkg::CHAR_UP_A) && (code <= rs2i_pkg::CHAR_UP_Z);
	assign is_lower = (code >= rs2i_pkg::CHAR_LO_A) && (code <= rs2i_pkg::CHAR_LO_Z);

	// digit value, max base when not alphanumeric
	always_comb begin
		logic [7:0] diff;
		diff = 8'd0;
		if (is_num) begin
			diff = code - rs2i_pkg::CHAR_0;
		end else if (is_upper) begin
			diff = code - rs2i_pkg::CHAR_UP_A + {2'b00, rs2i_pkg::LETTER_BASE};
		end else if (is_lower) begin
			diff = code - rs2i_pkg::CHAR_LO_A + {2'b00, rs2i_pkg::LETTER_BASE};
		end else begin
			diff = {2'b00, rs2i_pkg::MAX_BASE};
		end
		digit = diff[5:0];
	end

	// base is checked before the digit
	always_comb begin
		entry.digit = digit;
		entry.last  = in_req.last_char;
		if (radix > rs2i_pkg::MAX_BASE) begin
			entry.status = rs2i_pkg::ST_BAD_BASE;
		end else if ((digit >= rs2i_pkg::MAX_BASE) || (digit >= radix)) begin
			entry.status = rs2i_pkg::ST_BAD_DIGIT;
		end else begin
			entry.status = rs2i_pkg::ST_OK;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rs2i_queue.sv =====
// ----------------------------------------------------------------------------
// rs2i_queue
// short first-in first-out queue between classifier and accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module rs2i_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  var rs2i_pkg::entry_t  push_entry,
	output logic                  not_full,
	input  wire logic             pop,
	output rs2i_pkg::entry_t      pop_entry,
	output logic                  not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	rs2i_pkg::entry_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_full  = (count_q != FULL_CNT);
	assign not_empty = (count_q != '0);
	assign pop_entry = slots_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// sanity of the fill level
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !not_full)) else $error("queue pushed while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty)) else $error("queue popped while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/rs2i_back.sv =====
// ----------------------------------------------------------------------------
// rs2i_back
// multiply-add accumulator, error latch and result register
// ----------------------------------------------------------------------------
`default_nettype none

module rs2i_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [5:0]       radix,
	input  wire logic             q_valid,
	input  var rs2i_pkg::entry_t  q_entry,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output rs2i_pkg::out_res_t    out_res
);

	logic [30:0]          acc_q;
	rs2i_pkg::status_t    err_q;
	logic                 out_valid_q;
	rs2i_pkg::out_res_t   out_res_q;

	logic [37:0]          next_acc;
	logic                 ovf;
	rs2i_pkg::status_t    new_err;
	logic                 slot_free;

	// a result slot is free when empty or being taken
	assign slot_free = !out_valid_q || out_ready;
	assign pop       = q_valid && (!q_entry.last || slot_free);

	// multiply-add at full width and overflow check
	assign next_acc = ({7'd0, acc_q} * {32'd0, radix}) + {32'd0, q_entry.digit};
	assign ovf      = (next_acc[37:31] != '0);

	// first error of the string wins
	always_comb begin
		if (err_q != rs2i_pkg::ST_OK) begin
			new_err = err_q;
		end else if (q_entry.status != rs2i_pkg::ST_OK) begin
			new_err = q_entry.status;
		end else if (ovf) begin
			new_err = rs2i_pkg::ST_OVERFLOW;
		end else begin
			new_err = rs2i_pkg::ST_OK;
		end
	end

	// accumulator and error state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			err_q <= rs2i_pkg::ST_OK;
		end else if (pop) begin
			if (q_entry.last) begin
				acc_q <= '0;
				err_q <= rs2i_pkg::ST_OK;
			end else begin
				err_q <= new_err;
				if (new_err == rs2i_pkg::ST_OK) begin
					acc_q <= next_acc[30:0];
				end
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && q_entry.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && q_entry.last) begin
			out_res_q.status <= new_err;
			out_res_q.value  <= (new_err == rs2i_pkg::ST_OK) ? next_acc[30:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// checks
	a_value_zero_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_res_q.status != rs2i_pkg::ST_OK)) |-> (out_res_q.value == '0))
		else $error("non-zero value with error status");
	a_err_freezes_acc: assert property (@(posedge clk) disable iff (!arst_n)
		((err_q != rs2i_pkg::ST_OK) && !(pop && q_entry.last)) |=> $stable(acc_q))
		else $error("accumulator moved after an error");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_entry.last) |=> ((acc_q == '0) && (err_q == rs2i_pkg::ST_OK)))
		else $error("state not cleared after last character");

endmodule

`default_nettype wire

// ===== rtl/core/radix_string_to_integer.sv =====
// ----------------------------------------------------------------------------
// radix_string_to_integer
// converts a stream of ASCII digits in base 2 to 36 into a 31-bit integer
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_ready carry one character per request, last_char marks the
//   end of a number string. out_valid/out_ready carry one result (value and
//   status) per string, given on its last character.
//   the radix register sits at address 0 of the apb port; write it only
//   while no string is in flight. reset value is 10.
// throughput and datapath:
//   one character a cycle sustained while results are taken. a character is
//   classified on entry and written to a short queue; the accumulator takes
//   one queue entry a cycle, save a last character stalled by an occupied
//   result register, with a single 31x6 multiply-add. the result is registered.
// stalls and reset:
//   when out_ready is low the finished result waits in the output register;
//   the accumulator keeps taking characters until a further last character
//   finds the register occupied, then the queue fills and in_ready drops.
//   reset clears the accumulator, the error latch and the queue, and sets
//   the radix back to 10.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_string_to_integer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  var rs2i_pkg::in_req_t    in_req,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output rs2i_pkg::out_res_t       out_res,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [1:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	logic [5:0]        radix_q;
	rs2i_pkg::entry_t  front_entry;
	rs2i_pkg::entry_t  q_entry;
	logic              q_not_full;
	logic              q_not_empty;
	logic              q_pop;
	logic              push;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == rs2i_pkg::ADDR_RADIX) ? {26'd0, radix_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rs2i_pkg::RADIX_RESET;
		end else if (psel && penable && pwrite && (paddr == rs2i_pkg::ADDR_RADIX)) begin
			radix_q <= pwdata[5:0];
		end
	end

	// front: classify and queue
	assign in_ready = q_not_full;
	assign push     = in_valid && q_not_full;

	rs2i_front u_front (
		.in_req (in_req),
		.radix  (radix_q),
		.entry  (front_entry)
	);

	rs2i_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (front_entry),
		.not_full   (q_not_full),
		.pop        (q_pop),
		.pop_entry  (q_entry),
		.not_empty  (q_not_empty)
	);

	// back: accumulate and deliver
	rs2i_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.radix     (radix_q),
		.q_valid   (q_not_empty),
		.q_entry   (q_entry),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

endmodule

`default_nettype wire
